// ===== hdl/utfv_pkg.sv =====
// Shared state type, constants and whitespace helper function of the UTF-8 text validator.
package utfv_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned CountW = 11;

  localparam logic [7:0] AsciiMax = 8'h7f;
  localparam logic [7:0] Lead2Min = 8'hc2;
  localparam logic [7:0] Lead2Max = 8'hdf;
  localparam logic [7:0] Lead3Min = 8'he0;
  localparam logic [7:0] Lead3Max = 8'hef;
  localparam logic [7:0] Lead4Min = 8'hf0;
  localparam logic [7:0] Lead4Max = 8'hf4;
  localparam logic [5:0] ContMask = 6'h3f;

  localparam logic [1:0] SeqLen3 = 2'd2;
  localparam logic [1:0] SeqLen4 = 2'd3;

  localparam logic [CpW-1:0] SurrLo = 21'h00d800;
  localparam logic [CpW-1:0] SurrHi = 21'h00dfff;
  localparam logic [CpW-1:0] CpMax = 21'h10ffff;
  localparam logic [CpW-1:0] Min3Byte = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte = 21'h010000;

  // Decoder state carried from one byte of a string to the next.
  typedef struct packed {
    logic [1:0]     owed;
    logic [1:0]     seq_len;
    logic [CpW-1:0] acc;
    logic           err;
    logic           blank;
  } utfv_state_t;

  localparam utfv_state_t StateInit = '{
    owed: 2'd0, seq_len: 2'd0, acc: '0, err: 1'b0, blank: 1'b1
  };

  function automatic logic is_space(input logic [CpW-1:0] cp);
    logic res;
    res = (cp >= 21'h0009 && cp <= 21'h000d) || cp == 21'h0020 ||
          cp == 21'h0085 || cp == 21'h00a0 || cp == 21'h1680 ||
          (cp >= 21'h2000 && cp <= 21'h200a) || cp == 21'h2028 ||
          cp == 21'h2029 || cp == 21'h202f || cp == 21'h205f ||
          cp == 21'h3000;
    return res;
  endfunction

endpackage

// ===== hdl/utfv_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface utfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface utfv_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [10:0] scalar_count;
  logic        all_whitespace;

  modport source (output valid, output valid_res, output scalar_count,
                  output all_whitespace, input ready);
  modport sink   (input valid, input valid_res, input scalar_count,
                  input all_whitespace, output ready);
endinterface

// ===== hdl/utfv_step.sv =====
// Per-byte next-state logic of the UTF-8 decoder.
module utfv_step
  import utfv_pkg::*;
(
  input  utfv_state_t state_i,
  input  logic [7:0]  byte_i,
  output utfv_state_t state_o
);

  logic           is_cont;
  logic [CpW-1:0] cp;
  logic           bad_cp;

  assign is_cont = (byte_i[7:6] == 2'b10);
  assign cp = {state_i.acc[CpW-7:0], byte_i[5:0] & ContMask};
  assign bad_cp = (state_i.seq_len == SeqLen3 && cp < Min3Byte) ||
                  (state_i.seq_len == SeqLen4 && cp < Min4Byte) ||
                  (cp >= SurrLo && cp <= SurrHi) || (cp > CpMax);

  always_comb begin
    state_o = state_i;
    if (state_i.owed == 2'd0) begin
      if (byte_i <= AsciiMax) begin
        if (!is_space({13'd0, byte_i})) begin
          state_o.blank = 1'b0;
        end
      end else if (byte_i >= Lead2Min && byte_i <= Lead2Max) begin
        state_o.owed    = 2'd1;
        state_o.seq_len = 2'd1;
        state_o.acc     = {16'd0, byte_i[4:0]};
      end else if (byte_i >= Lead3Min && byte_i <= Lead3Max) begin
        state_o.owed    = 2'd2;
        state_o.seq_len = 2'd2;
        state_o.acc     = {17'd0, byte_i[3:0]};
      end else if (byte_i >= Lead4Min && byte_i <= Lead4Max) begin
        state_o.owed    = 2'd3;
        state_o.seq_len = 2'd3;
        state_o.acc     = {18'd0, byte_i[2:0]};
      end else begin
        state_o.err = 1'b1;
      end
    end else if (!is_cont) begin
      // The pending sequence is abandoned; this byte does not start a new one.
      state_o.err     = 1'b1;
      state_o.owed    = 2'd0;
      state_o.seq_len = 2'd0;
      state_o.acc     = '0;
    end else begin
      state_o.owed = state_i.owed - 2'd1;
      state_o.acc  = cp;
      if (state_i.owed == 2'd1) begin
        if (bad_cp) begin
          state_o.err = 1'b1;
        end
        if (!is_space(cp)) begin
          state_o.blank = 1'b0;
        end
        state_o.seq_len = 2'd0;
        state_o.acc     = '0;
      end
    end
  end

endmodule

// ===== hdl/utf8_text_validator_core.sv =====
// Top level of the streaming strict UTF-8 text validator.
//
// Strings arrive on in_i one byte per item, with last set on the final byte
// of each string. Empty strings cannot be presented. For every string one
// result item leaves on out_o when its last byte has been processed:
// valid_res tells whether the string is strict UTF-8, scalar_count gives the
// number of non-continuation bytes (saturating at MAX_BYTES, low 11 bits
// shown) and all_whitespace is set when the string is valid and every code
// point in it is Unicode whitespace.
//
// The block has two register stages: an input register that captures the
// byte, and the decoder state together with the result register. A byte
// is taken in every cycle while the output side keeps up, so throughput is
// one item per cycle. A result appears on out_o once its last byte has
// moved from the input register into the result register stage. When
// out_o stalls, a finished result waits in the result register; bytes that
// do not end a string still move on, and only a further last byte waits in
// the input register, which then drops in_i.ready.
// Reset clears both valid flags and returns the decoder to its start state.
module utf8_text_validator_core
  import utfv_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  utfv_in_if.sink  in_i,
  utfv_out_if.source out_o
);

  localparam int unsigned TallyW = $clog2(MAX_BYTES + 1);
  localparam logic [TallyW-1:0] TallyMax = TallyW'(MAX_BYTES);

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Decoder state and saturating tally.
  utfv_state_t        state_q, state_d, state_step;
  logic [TallyW-1:0]  tally_q, tally_d, tally_step;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic        res_ok_q;
  logic [10:0] res_count_q;
  logic        res_blank_q;

  logic out_free;
  logic advance;
  logic take_in;
  logic res_ok;

  // The result slot is free when empty or being emptied this cycle. A byte
  // that does not finish a string needs no slot and always moves on.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || advance;
  assign take_in  = in_i.valid && in_i.ready;

  utfv_step u_step (
    .state_i (state_q),
    .byte_i  (s1_byte_q),
    .state_o (state_step)
  );

  assign tally_step = (s1_byte_q[7:6] != 2'b10 && tally_q < TallyMax) ?
                      tally_q + TallyW'(1) : tally_q;
  assign res_ok = !state_step.err && state_step.owed == 2'd0;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    state_d     = state_q;
    tally_d     = tally_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      s1_valid_d = 1'b0;
      if (s1_last_q) begin
        // The string is complete: show its result and start afresh.
        out_valid_d = 1'b1;
        state_d     = StateInit;
        tally_d     = '0;
      end else begin
        state_d = state_step;
        tally_d = tally_step;
      end
    end
    if (take_in) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateInit;
      tally_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      tally_q     <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last;
    end
    if (advance && s1_last_q) begin
      res_ok_q    <= res_ok;
      res_count_q <= CountW'(tally_step);
      res_blank_q <= res_ok && state_step.blank;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.valid_res      = res_ok_q;
  assign out_o.scalar_count   = res_count_q;
  assign out_o.all_whitespace = res_blank_q;

endmodule

// ===== hdl/utfv_checker.sv =====
// Port-level checks of the UTF-8 text validator, bound to the top level.
module utfv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        valid_res_i,
  input logic [10:0] scalar_count_i,
  input logic        all_whitespace_i
);

  logic       last_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;

  // Strings whose last byte has gone in but whose result is not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, last_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a completed string");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more strings in flight than the block can hold");

  a_blank_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && all_whitespace_i |-> valid_res_i && scalar_count_i != 11'd0)
    else $error("whitespace flag on an invalid or empty string");

endmodule

bind utf8_text_validator_core utfv_checker u_utfv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .valid_res_i      (out_o.valid_res),
  .scalar_count_i   (out_o.scalar_count),
  .all_whitespace_i (out_o.all_whitespace)
);
